[hw/rtl/limit_order_matcher_top_assert.svh]
// Assertion macros used by the order matcher controller.
// Included by the controller; no other dependencies.
`ifndef LIMIT_ORDER_MATCHER_TOP_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_TOP_ASSERT_SVH

// Implication that must hold whenever out of reset.
`define LOM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked on the following cycle.
`define LOM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/lom_pkg.sv]
// Package for the limit order matcher: constants, result kinds, control structs.
// No dependencies.
`default_nettype none
package lom_pkg;
    localparam int BookDepthDefault  = 32;
    localparam int NumSymbolsDefault = 8;

    localparam int SymW   = 3;
    localparam int IdW    = 32;
    localparam int PriceW = 20;
    localparam int QtyW   = 24;
    localparam int UserW  = 16;
    localparam int TimeW  = 32;
    localparam int KindW  = 3;
    localparam int TnumW  = 32;

    localparam logic [KindW-1:0] KIND_TRADE    = 3'd0;
    localparam logic [KindW-1:0] KIND_DONE     = 3'd1;
    localparam logic [KindW-1:0] KIND_FULL     = 3'd2;
    localparam logic [KindW-1:0] KIND_CANCEL   = 3'd3;
    localparam logic [KindW-1:0] KIND_NOTFOUND = 3'd4;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item
        logic scan;      // run one best/cancel/free search
        logic trade;     // apply the searched trade, build trade result
        logic cancel;    // free found entry, build cancel result
        logic finish;    // rest remainder or reject, build final result
        logic out_load;  // move built result into output register
    } lom_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_cancel;
        logic rem_zero;
        logic best_found;
    } lom_stat_t;
endpackage
`default_nettype wire

[hw/rtl/limit_order_matcher_top.sv]
// Top level of the limit order matcher: controller plus datapath.
// Depends on lom_pkg, lom_ctrl, lom_datapath.
//
// Price-time priority matcher over a shared book of BOOK_DEPTH slots. Each item
// is handled alone: after capture, each result takes one search over the whole
// book with a registered result, one update and one output move, and the move
// waits while the output is stalled. A submit gives up to BOOK_DEPTH trades and
// then its final result; a cancel gives one result. The output register lets the
// last result wait while the next item is accepted.
`default_nettype none
module limit_order_matcher_top #(
    parameter int BOOK_DEPTH  = lom_pkg::BookDepthDefault,
    parameter int NUM_SYMBOLS = lom_pkg::NumSymbolsDefault
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_stall,
    input  wire                          command,
    input  wire [lom_pkg::SymW-1:0]      symbol,
    input  wire [lom_pkg::IdW-1:0]       order_tag,
    input  wire                          side,
    input  wire [lom_pkg::PriceW-1:0]    price,
    input  wire [lom_pkg::QtyW-1:0]      quantity,
    input  wire [lom_pkg::UserW-1:0]     user,
    input  wire [lom_pkg::TimeW-1:0]     timestamp,
    output logic                         out_valid,
    input  wire                          out_stall,
    output logic [lom_pkg::KindW-1:0]    kind,
    output logic [lom_pkg::TnumW-1:0]    trade_number,
    output logic [lom_pkg::UserW-1:0]    buyer,
    output logic [lom_pkg::UserW-1:0]    seller,
    output logic [lom_pkg::SymW-1:0]     trade_symbol,
    output logic [lom_pkg::PriceW-1:0]   trade_price,
    output logic [lom_pkg::QtyW-1:0]     amount,
    output logic                         last
);
    lom_pkg::lom_cmd_t  cmd;
    lom_pkg::lom_stat_t stat;

    lom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    lom_datapath #(
        .BOOK_DEPTH  (BOOK_DEPTH),
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_command   (command),
        .in_symbol    (symbol),
        .in_order_tag (order_tag),
        .in_side      (side),
        .in_price     (price),
        .in_quantity  (quantity),
        .in_user      (user),
        .in_timestamp (timestamp),
        .kind         (kind),
        .trade_number (trade_number),
        .buyer        (buyer),
        .seller       (seller),
        .trade_symbol (trade_symbol),
        .trade_price  (trade_price),
        .amount       (amount),
        .last         (last)
    );
endmodule
`default_nettype wire

[hw/rtl/lom_datapath.sv]
// Datapath of the order matcher: order book table, registered search, trade math.
// Depends on lom_pkg.
`default_nettype none
module lom_datapath #(
    parameter int BOOK_DEPTH  = lom_pkg::BookDepthDefault,
    parameter int NUM_SYMBOLS = lom_pkg::NumSymbolsDefault
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire lom_pkg::lom_cmd_t       cmd,
    output lom_pkg::lom_stat_t           stat,
    input  wire                          in_command,
    input  wire [lom_pkg::SymW-1:0]      in_symbol,
    input  wire [lom_pkg::IdW-1:0]       in_order_tag,
    input  wire                          in_side,
    input  wire [lom_pkg::PriceW-1:0]    in_price,
    input  wire [lom_pkg::QtyW-1:0]      in_quantity,
    input  wire [lom_pkg::UserW-1:0]     in_user,
    input  wire [lom_pkg::TimeW-1:0]     in_timestamp,
    output logic [lom_pkg::KindW-1:0]    kind,
    output logic [lom_pkg::TnumW-1:0]    trade_number,
    output logic [lom_pkg::UserW-1:0]    buyer,
    output logic [lom_pkg::UserW-1:0]    seller,
    output logic [lom_pkg::SymW-1:0]     trade_symbol,
    output logic [lom_pkg::PriceW-1:0]   trade_price,
    output logic [lom_pkg::QtyW-1:0]     amount,
    output logic                         last
);
    localparam int IdxW = $clog2(BOOK_DEPTH);

    // Book table
    logic [BOOK_DEPTH-1:0]     valid_reg;
    logic                      e_side   [BOOK_DEPTH];
    logic [lom_pkg::SymW-1:0]  e_sym    [BOOK_DEPTH];
    logic [lom_pkg::PriceW-1:0] e_price [BOOK_DEPTH];
    logic [lom_pkg::QtyW-1:0]  e_rem    [BOOK_DEPTH];
    logic [lom_pkg::IdW-1:0]   e_id     [BOOK_DEPTH];
    logic [lom_pkg::UserW-1:0] e_user   [BOOK_DEPTH];
    logic [lom_pkg::TimeW-1:0] e_time   [BOOK_DEPTH];

    // Captured item
    logic                       cmd_reg;
    logic [lom_pkg::SymW-1:0]   sym_reg;
    logic [lom_pkg::IdW-1:0]    id_reg;
    logic                       side_reg;
    logic [lom_pkg::PriceW-1:0] price_reg;
    logic [lom_pkg::QtyW-1:0]   rem_reg;
    logic [lom_pkg::UserW-1:0]  user_reg;
    logic [lom_pkg::TimeW-1:0]  time_reg;
    logic [lom_pkg::TnumW-1:0]  tcount_reg;

    // Search result registers
    logic                       found_reg;
    logic [IdxW-1:0]            best_reg;
    logic                       free_ok_reg;
    logic [IdxW-1:0]            free_reg;

    // Built result
    logic [lom_pkg::KindW-1:0]  rkind_reg;
    logic [lom_pkg::TnumW-1:0]  rtnum_reg;
    logic [lom_pkg::UserW-1:0]  rbuyer_reg;
    logic [lom_pkg::UserW-1:0]  rseller_reg;
    logic [lom_pkg::PriceW-1:0] rprice_reg;
    logic [lom_pkg::QtyW-1:0]   ramount_reg;
    logic                       rlast_reg;

    // Symbol folded into range: small lookup over every input code
    logic [lom_pkg::SymW-1:0]   sym_mod;
    always_comb
    begin
        sym_mod = '0;
        for (int v = 0; v < 2**lom_pkg::SymW; v++)
        begin
            if (in_symbol == lom_pkg::SymW'(v))
                sym_mod = lom_pkg::SymW'(v % NUM_SYMBOLS);
        end
    end

    // Candidate mask: crossing opposite side entries (or cancel matches)
    logic [BOOK_DEPTH-1:0] cand;
    always_comb
    begin
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            if (cmd_reg == lom_pkg::CMD_CANCEL)
                cand[i] = valid_reg[i] && e_sym[i] == sym_reg && e_id[i] == id_reg;
            else
                cand[i] = valid_reg[i] && e_sym[i] == sym_reg && e_side[i] != side_reg &&
                          (side_reg ? (e_price[i] >= price_reg) : (e_price[i] <= price_reg));
        end
    end

    // Pairwise better-than: a beats b (a lower index than b on full ties)
    function automatic logic beats(input logic side, input logic va, input logic vb,
                                   input logic [lom_pkg::PriceW-1:0] pa,
                                   input logic [lom_pkg::PriceW-1:0] pb,
                                   input logic [lom_pkg::TimeW-1:0] ta,
                                   input logic [lom_pkg::TimeW-1:0] tb,
                                   input logic cancel);
        logic r;
        begin
            if (!va)
                r = 1'b0;
            else if (!vb)
                r = 1'b1;
            else if (cancel)
                r = 1'b1;
            else if (pa != pb)
                r = side ? (pa > pb) : (pa < pb);
            else
                r = (ta <= tb);
            return r;
        end
    endfunction

    // Tournament selection over the book: each entry wins if it beats all others
    logic [BOOK_DEPTH-1:0] win;
    always_comb
    begin
        for (int i = 0; i < BOOK_DEPTH; i++)
        begin
            win[i] = cand[i];
            for (int j = 0; j < BOOK_DEPTH; j++)
            begin
                if (j < i)
                    win[i] = win[i] && !beats(side_reg, cand[j], cand[i], e_price[j],
                                  e_price[i], e_time[j], e_time[i], cmd_reg);
                else if (j > i)
                    win[i] = win[i] && beats(side_reg, cand[i], cand[j], e_price[i],
                                  e_price[j], e_time[i], e_time[j], cmd_reg);
            end
        end
    end

    logic [IdxW-1:0] win_idx;
    logic [IdxW-1:0] free_idx;
    always_comb
    begin
        win_idx  = '0;
        free_idx = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if (win[i])
                win_idx = IdxW'(i);
            if (!valid_reg[i])
                free_idx = IdxW'(i);
        end
    end

    // Trade quantity
    logic [lom_pkg::QtyW-1:0] tq;
    assign tq = (rem_reg < e_rem[best_reg]) ? rem_reg : e_rem[best_reg];

    assign stat.is_cancel  = cmd_reg;
    assign stat.rem_zero   = (rem_reg == '0);
    assign stat.best_found = found_reg;

    // Control registers: valid bits, trade counter, search results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            tcount_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.scan)
                found_reg <= |win;
            if (cmd.trade)
            begin
                tcount_reg <= tcount_reg + 1'b1;
                if (tq == e_rem[best_reg])
                    valid_reg[best_reg] <= 1'b0;
            end
            if (cmd.cancel && found_reg)
                valid_reg[best_reg] <= 1'b0;
            if (cmd.finish && !cmd_reg && rem_reg != '0 && free_ok_reg)
                valid_reg[free_reg] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_command;
            sym_reg   <= sym_mod;
            id_reg    <= in_order_tag;
            side_reg  <= in_side;
            price_reg <= in_price;
            rem_reg   <= in_quantity;
            user_reg  <= in_user;
            time_reg  <= in_timestamp;
        end
        if (cmd.scan)
        begin
            best_reg    <= win_idx;
            free_reg    <= free_idx;
            free_ok_reg <= !(&valid_reg);
        end
        if (cmd.trade)
        begin
            rem_reg          <= rem_reg - tq;
            e_rem[best_reg]  <= e_rem[best_reg] - tq;
            rkind_reg   <= lom_pkg::KIND_TRADE;
            rtnum_reg   <= tcount_reg;
            rbuyer_reg  <= side_reg ? e_user[best_reg] : user_reg;
            rseller_reg <= side_reg ? user_reg : e_user[best_reg];
            rprice_reg  <= e_price[best_reg];
            ramount_reg <= tq;
            rlast_reg   <= 1'b0;
        end
        if (cmd.cancel)
        begin
            rkind_reg   <= found_reg ? lom_pkg::KIND_CANCEL : lom_pkg::KIND_NOTFOUND;
            rtnum_reg   <= '0;
            rbuyer_reg  <= '0;
            rseller_reg <= '0;
            rprice_reg  <= found_reg ? e_price[best_reg] : '0;
            ramount_reg <= found_reg ? e_rem[best_reg] : '0;
            rlast_reg   <= 1'b1;
        end
        if (cmd.finish)
        begin
            rkind_reg   <= (rem_reg != '0 && !free_ok_reg) ? lom_pkg::KIND_FULL
                                                           : lom_pkg::KIND_DONE;
            rtnum_reg   <= '0;
            rbuyer_reg  <= '0;
            rseller_reg <= '0;
            rprice_reg  <= price_reg;
            ramount_reg <= rem_reg;
            rlast_reg   <= 1'b1;
            if (rem_reg != '0 && free_ok_reg)
            begin
                e_side[free_reg]  <= side_reg;
                e_sym[free_reg]   <= sym_reg;
                e_price[free_reg] <= price_reg;
                e_rem[free_reg]   <= rem_reg;
                e_id[free_reg]    <= id_reg;
                e_user[free_reg]  <= user_reg;
                e_time[free_reg]  <= time_reg;
            end
        end
        if (cmd.out_load)
        begin
            kind         <= rkind_reg;
            trade_number <= rtnum_reg;
            buyer        <= rbuyer_reg;
            seller       <= rseller_reg;
            trade_symbol <= sym_reg;
            trade_price  <= rprice_reg;
            amount       <= ramount_reg;
            last         <= rlast_reg;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/lom_ctrl.sv]
// Sequencer of the order matcher: handshakes and per-item step order.
// Depends on lom_pkg and limit_order_matcher_top_assert.svh.
`default_nettype none
`include "limit_order_matcher_top_assert.svh"
module lom_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire                    out_stall,
    input  wire lom_pkg::lom_stat_t stat,
    output lom_pkg::lom_cmd_t      cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_BUILT = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       lastb_reg, lastb_next;   // built result ends the item

    logic out_free;
    assign out_free = !ovalid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        lastb_next  = lastb_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (stat.is_cancel)
                begin
                    cmd.cancel = 1'b1;
                    lastb_next = 1'b1;
                end
                else if (!stat.rem_zero && stat.best_found)
                begin
                    cmd.trade  = 1'b1;
                    lastb_next = 1'b0;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    lastb_next = 1'b1;
                end
                state_next = S_BUILT;
            end
            S_BUILT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = lastb_reg ? S_IDLE : S_SCAN;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            lastb_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            lastb_reg  <= lastb_next;
        end
    end

    assign out_valid = ovalid_reg;

    `LOM_ASSERT_IMPL(a_one_step, clk, rst_n, 1'b1,
        $countones({cmd.trade, cmd.cancel, cmd.finish}) <= 1)
    `LOM_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load, state_reg == S_IDLE)
    `LOM_ASSERT_NEXT(a_out_set, clk, rst_n, cmd.out_load, out_valid)
    `LOM_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_valid && out_stall, !cmd.out_load)
endmodule
`default_nettype wire
